/* design/pitb_pkg.sv */
// Package for the barycentric point-in-triangle block.
// Holds widths, pipeline payload types and small arithmetic helpers; no dependencies.
package pitb_pkg;

    localparam int COORD_BITS = 32;                   // significant coordinate bits
    localparam int FRAC_BITS  = 30;                   // fraction bits of each weight
    localparam int FIELD_W    = 32;                   // width of a coordinate field
    localparam int WEIGHT_W   = 32;                   // width of a weight field
    localparam int TOL_W      = 30;                   // width of the tolerance register
    localparam int DIFF_W     = COORD_BITS + 1;       // coordinate difference
    localparam int PROD_W     = 2 * DIFF_W;           // product of two differences
    localparam int SUM_W      = PROD_W + 1;           // determinant or numerator
    localparam int MAG_W      = SUM_W - 1;            // magnitude of those
    localparam int DVD_W      = MAG_W + FRAC_BITS;    // scaled dividend, also quotient width
    localparam int Q_W        = DVD_W + 1;            // signed quotient
    localparam int QC_W       = Q_W + 2;              // room for 1 - a - b
    localparam int BND_W      = WEIGHT_W + 2;         // bound compare width
    localparam int S_TDATA_W  = 8 * FIELD_W;
    localparam int M_TDATA_W  = ((1 + 3 * WEIGHT_W + 7) / 8) * 8;

    // One division lane: partial remainder and the dividend that turns into the quotient.
    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [DVD_W-1:0] dvd;
    } lane_t;

    typedef struct packed {
        logic             valid;
        logic             deg;
        logic             neg_a;
        logic             neg_b;
        logic [MAG_W-1:0] divisor;
        lane_t            lane_a;
        lane_t            lane_b;
    } cell_t;

    typedef struct packed {
        logic                in_tri;
        logic                deg;
        logic [WEIGHT_W-1:0] wa;
        logic [WEIGHT_W-1:0] wb;
        logic [WEIGHT_W-1:0] wc;
    } res_t;

    function automatic logic signed [DIFF_W-1:0] sext_coord(input logic [FIELD_W-1:0] raw);
        return $signed({{(DIFF_W - COORD_BITS){raw[COORD_BITS-1]}}, raw[COORD_BITS-1:0]});
    endfunction

    // Clamp a wide signed value to the weight range.
    function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [QC_W-1:0] x);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &x[QC_W-1:WEIGHT_W-1];
        hi_zeros = ~|x[QC_W-1:WEIGHT_W-1];
        if (hi_ones || hi_zeros) begin
            return x[WEIGHT_W-1:0];
        end else if (x[QC_W-1]) begin
            return {1'b1, {(WEIGHT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
    endfunction

    function automatic logic in_bounds(input logic [WEIGHT_W-1:0] w,
                                       input logic [TOL_W-1:0] tol);
        logic signed [BND_W-1:0] ws;
        logic signed [BND_W-1:0] lo;
        logic signed [BND_W-1:0] hi;
        ws = $signed({{(BND_W - WEIGHT_W){w[WEIGHT_W-1]}}, w});
        lo = -$signed({{(BND_W - TOL_W){1'b0}}, tol});
        hi = $signed(BND_W'(1) << FRAC_BITS) + $signed({{(BND_W - TOL_W){1'b0}}, tol});
        return (ws >= lo) && (ws <= hi);
    endfunction

endpackage

/* design/pitb_prep.sv */
// Front end: coordinate differences, the six products, determinant and numerators.
// Ends by loading the first division cell. Depends on pitb_pkg.
module pitb_prep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [pitb_pkg::S_TDATA_W-1:0] in_data,
    output pitb_pkg::cell_t               cell_out
);
    import pitb_pkg::*;

    logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy, px, py;
    logic signed [DIFF_W-1:0] dbc_y_reg, dcb_x_reg, dca_y_reg, dac_x_reg, dac_y_reg;
    logic signed [DIFF_W-1:0] dpc_x_reg, dpc_y_reg;
    logic signed [PROD_W-1:0] p_det0_reg, p_det1_reg, p_na0_reg, p_na1_reg;
    logic signed [PROD_W-1:0] p_nb0_reg, p_nb1_reg;
    logic signed [SUM_W-1:0]  det_reg, na_reg, nb_reg;
    logic [2:0]               valid_reg;
    logic                     det_neg, na_neg, nb_neg;
    logic [SUM_W-1:0]         det_abs, na_abs, nb_abs;
    cell_t                    cell_next;
    cell_t                    cell_reg;

    assign ax = sext_coord(in_data[0*FIELD_W +: FIELD_W]);
    assign ay = sext_coord(in_data[1*FIELD_W +: FIELD_W]);
    assign bx = sext_coord(in_data[2*FIELD_W +: FIELD_W]);
    assign by = sext_coord(in_data[3*FIELD_W +: FIELD_W]);
    assign cx = sext_coord(in_data[4*FIELD_W +: FIELD_W]);
    assign cy = sext_coord(in_data[5*FIELD_W +: FIELD_W]);
    assign px = sext_coord(in_data[6*FIELD_W +: FIELD_W]);
    assign py = sext_coord(in_data[7*FIELD_W +: FIELD_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            valid_reg      <= {valid_reg[1:0], in_valid};
            cell_reg.valid <= valid_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dbc_y_reg  <= by - cy;
            dcb_x_reg  <= cx - bx;
            dca_y_reg  <= cy - ay;
            dac_x_reg  <= ax - cx;
            dac_y_reg  <= ay - cy;
            dpc_x_reg  <= px - cx;
            dpc_y_reg  <= py - cy;
            p_det0_reg <= dbc_y_reg * dac_x_reg;
            p_det1_reg <= dcb_x_reg * dac_y_reg;
            p_na0_reg  <= dbc_y_reg * dpc_x_reg;
            p_na1_reg  <= dcb_x_reg * dpc_y_reg;
            p_nb0_reg  <= dca_y_reg * dpc_x_reg;
            p_nb1_reg  <= dac_x_reg * dpc_y_reg;
            det_reg    <= SUM_W'(p_det0_reg) + SUM_W'(p_det1_reg);
            na_reg     <= SUM_W'(p_na0_reg) + SUM_W'(p_na1_reg);
            nb_reg     <= SUM_W'(p_nb0_reg) + SUM_W'(p_nb1_reg);
            cell_reg.deg     <= cell_next.deg;
            cell_reg.neg_a   <= cell_next.neg_a;
            cell_reg.neg_b   <= cell_next.neg_b;
            cell_reg.divisor <= cell_next.divisor;
            cell_reg.lane_a  <= cell_next.lane_a;
            cell_reg.lane_b  <= cell_next.lane_b;
        end
    end

    always_comb begin
        det_neg = det_reg[SUM_W-1];
        na_neg  = na_reg[SUM_W-1];
        nb_neg  = nb_reg[SUM_W-1];
        det_abs = det_neg ? -det_reg : det_reg;
        na_abs  = na_neg ? -na_reg : na_reg;
        nb_abs  = nb_neg ? -nb_reg : nb_reg;
        cell_next            = '0;
        cell_next.deg        = (det_reg == '0);
        cell_next.neg_a      = na_neg ^ det_neg;
        cell_next.neg_b      = nb_neg ^ det_neg;
        cell_next.divisor    = det_abs[MAG_W-1:0];
        cell_next.lane_a.rem = '0;
        cell_next.lane_a.dvd = {na_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
        cell_next.lane_b.rem = '0;
        cell_next.lane_b.dvd = {nb_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    end

    assign cell_out = cell_reg;

endmodule

/* design/pitb_div_cell.sv */
// One restoring-division cell: produces one quotient bit for each of the two lanes.
// Depends on pitb_pkg.
module pitb_div_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  pitb_pkg::cell_t cell_in,
    output pitb_pkg::cell_t cell_out
);
    import pitb_pkg::*;

    cell_t            cell_reg;
    cell_t            cell_next;
    logic [MAG_W:0]   trial_a, trial_b;
    logic [MAG_W:0]   diff_a, diff_b;

    always_comb begin
        trial_a   = {cell_in.lane_a.rem, cell_in.lane_a.dvd[DVD_W-1]};
        trial_b   = {cell_in.lane_b.rem, cell_in.lane_b.dvd[DVD_W-1]};
        diff_a    = trial_a - {1'b0, cell_in.divisor};
        diff_b    = trial_b - {1'b0, cell_in.divisor};
        cell_next = cell_in;
        // A quotient bit of one means the trial remainder did not go negative.
        if (trial_a >= {1'b0, cell_in.divisor}) begin
            cell_next.lane_a.rem = diff_a[MAG_W-1:0];
            cell_next.lane_a.dvd = {cell_in.lane_a.dvd[DVD_W-2:0], 1'b1};
        end else begin
            cell_next.lane_a.rem = trial_a[MAG_W-1:0];
            cell_next.lane_a.dvd = {cell_in.lane_a.dvd[DVD_W-2:0], 1'b0};
        end
        if (trial_b >= {1'b0, cell_in.divisor}) begin
            cell_next.lane_b.rem = diff_b[MAG_W-1:0];
            cell_next.lane_b.dvd = {cell_in.lane_b.dvd[DVD_W-2:0], 1'b1};
        end else begin
            cell_next.lane_b.rem = trial_b[MAG_W-1:0];
            cell_next.lane_b.dvd = {cell_in.lane_b.dvd[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg.valid <= cell_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell_reg.deg     <= cell_next.deg;
            cell_reg.neg_a   <= cell_next.neg_a;
            cell_reg.neg_b   <= cell_next.neg_b;
            cell_reg.divisor <= cell_next.divisor;
            cell_reg.lane_a  <= cell_next.lane_a;
            cell_reg.lane_b  <= cell_next.lane_b;
        end
    end

    assign cell_out = cell_reg;

endmodule

/* design/pitb_post.sv */
// Back end: signs the quotients, forms the third weight, saturates and runs the bound test.
// Depends on pitb_pkg.
module pitb_post (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  pitb_pkg::cell_t           cell_in,
    input  logic [pitb_pkg::TOL_W-1:0] tol,
    output logic                      res_valid,
    output pitb_pkg::res_t            res
);
    import pitb_pkg::*;

    logic [3:0]          valid_reg;
    logic [2:0]          deg_reg;
    logic [Q_W-1:0]      qa_reg, qb_reg;
    logic [QC_W-1:0]     qc_reg;
    logic [WEIGHT_W-1:0] wa_reg, wb_reg, wa2_reg, wb2_reg, wc_reg;
    logic [Q_W-1:0]      qa_next, qb_next;
    logic [QC_W-1:0]     qa_ext, qb_ext, qc_next;
    res_t                res_reg;
    res_t                res_next;

    always_comb begin
        qa_next = cell_in.neg_a ? -{1'b0, cell_in.lane_a.dvd} : {1'b0, cell_in.lane_a.dvd};
        qb_next = cell_in.neg_b ? -{1'b0, cell_in.lane_b.dvd} : {1'b0, cell_in.lane_b.dvd};
        qa_ext  = {{(QC_W - Q_W){qa_reg[Q_W-1]}}, qa_reg};
        qb_ext  = {{(QC_W - Q_W){qb_reg[Q_W-1]}}, qb_reg};
        qc_next = (QC_W'(1) << FRAC_BITS) - qa_ext - qb_ext;
    end

    always_comb begin
        res_next = '0;
        res_next.deg = deg_reg[2];
        if (!deg_reg[2]) begin
            res_next.wa     = wa2_reg;
            res_next.wb     = wb2_reg;
            res_next.wc     = wc_reg;
            res_next.in_tri = in_bounds(wa2_reg, tol) && in_bounds(wb2_reg, tol)
                              && in_bounds(wc_reg, tol);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], cell_in.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            deg_reg <= {deg_reg[1:0], cell_in.deg};
            qa_reg  <= qa_next;
            qb_reg  <= qb_next;
            qc_reg  <= qc_next;
            wa_reg  <= sat_weight({{(QC_W - Q_W){qa_reg[Q_W-1]}}, qa_reg});
            wb_reg  <= sat_weight({{(QC_W - Q_W){qb_reg[Q_W-1]}}, qb_reg});
            wa2_reg <= wa_reg;
            wb2_reg <= wb_reg;
            wc_reg  <= sat_weight(qc_reg);
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg[3];
    assign res       = res_reg;

endmodule

/* design/point_in_triangle_barycentric.sv */
// Top level of the barycentric point-in-triangle test.
// Instantiates pitb_prep, a row of pitb_div_cell and pitb_post; uses pitb_pkg.
//
// One test enters per clock while the output queue has room, and one result leaves
// per clock while m_tready is high. The pipeline is made of four front-end stages for
// the differences, products and sums, one division cell per quotient bit, four
// back-end stages for signing, saturation and the bound test, and the output
// register. The output holds two results, so an input transaction is still taken in
// the cycle in which a finished result waits; the whole pipeline holds only when
// both output entries are full. The user must write the tolerance register through
// cfg_we and cfg_wdata only while no test is in flight; the block does not check it.
module point_in_triangle_barycentric (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [pitb_pkg::TOL_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    // query_x, query_y, 32 bits each from bit 0 up
    input  logic [pitb_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // inside_res [0], weight_a [32:1], weight_b [64:33], weight_c [96:65], zero fill
    output logic [pitb_pkg::M_TDATA_W-1:0] m_tdata,
    // degenerate [0]
    output logic                           m_tuser
);
    import pitb_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    logic             en;
    cell_t            chain [DVD_W+1];
    logic             res_valid;
    res_t             res;
    res_t             head_reg, spare_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    assign en = (count_reg != 2'd2);

    pitb_prep u_prep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .cell_out (chain[0])
    );

    for (genvar i = 0; i < DVD_W; i++) begin : g_cell
        pitb_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    pitb_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cell_in   (chain[DVD_W]),
        .tol       (tol_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Two-entry output queue; the head entry drives the result ports.
    assign push = en && res_valid;
    assign pop  = (count_reg != 2'd0) && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (pop && count_reg == 2'd2) begin
            count_reg <= 2'd1;
        end else if (pop && !push) begin
            count_reg <= count_reg - 2'd1;
        end else if (!pop && push) begin
            count_reg <= count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && count_reg == 2'd2) begin
            head_reg <= spare_reg;
        end else if (push && (count_reg == 2'd0 || pop)) begin
            head_reg <= res;
        end else if (push) begin
            spare_reg <= res;
        end
    end

    assign s_tready = en;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tuser  = head_reg.deg;
    assign m_tdata  = M_TDATA_W'({head_reg.wc, head_reg.wb, head_reg.wa, head_reg.in_tri});

endmodule

/* design/pitb_checker.sv */
// Port-level checks for the point-in-triangle block, bound to its top level.
// Depends on pitb_pkg and point_in_triangle_barycentric.
module pitb_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [pitb_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           m_tuser
);
    import pitb_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_deg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result carries weights or inside flag");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind point_in_triangle_barycentric pitb_checker u_pitb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
